// File: sv/ptuc_pkg.sv
// ----------------------------------------------------------------------------
// ptuc_pkg
// Types, constants and register codes shared by the power trace converter.
// ----------------------------------------------------------------------------
package ptuc_pkg;

	localparam int unsigned MAX_POINTS = 5001;

	// 1000*log10(2) in Q9.54
	localparam logic [63:0] LOG10_2_X1000_Q54 = 64'd5422874305198590949;

	localparam logic signed [13:0] DBM_FLOOR   = -14'sd3000;
	localparam logic signed [31:0] RANGE_HI_UW = 32'sd1000000000;
	localparam logic signed [31:0] RANGE_LO_UW = 32'sd1000000;

	localparam int unsigned DIV_STEPS  = 45;
	localparam int unsigned SQRT_STEPS = 24;
	localparam int unsigned SQ_STEPS   = 59;

	localparam int unsigned QDEPTH = 2;

	typedef enum logic [2:0] {
		REG_CAPTURE_ENABLE   = 3'd0,
		REG_POINT_COUNT      = 3'd1,
		REG_TRACE_TIME_NS    = 3'd2,
		REG_TRACE_OFFSET_NS  = 3'd3,
		REG_CAVITY_FACTOR    = 3'd4,
		REG_TRIG_INTERNAL    = 3'd5,
		REG_TRIGGER_LEVEL_UW = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RANGE_LOW  = 2'd0,
		RANGE_MID  = 2'd1,
		RANGE_HIGH = 2'd2
	} range_t;

	typedef struct packed {
		logic               capture_enable;
		logic [12:0]        point_count;
		logic [31:0]        trace_time_ns;
		logic signed [31:0] trace_offset_ns;
		logic [23:0]        cavity_factor;
		logic               trig_internal;
		logic [31:0]        trigger_level_uw;
	} cfg_t;

	// one classified sample between front and back
	typedef struct packed {
		logic        err;
		logic [31:0] mag;
		logic [12:0] idx;
		logic        last;
		range_t      range_code;
	} item_t;

	typedef struct packed {
		logic signed [33:0] time_ns;
		logic signed [13:0] power_dbm;
		logic               zero_power;
		logic [23:0]        field_strength;
		logic               last;
		range_t             range_code;
		logic               trig_valid;
		logic signed [13:0] trig_dbm;
		logic               error;
	} res_t;

endpackage

// File: sv/power_trace_unit_converter.sv
// ----------------------------------------------------------------------------
// power_trace_unit_converter
// Converts power samples of a trace to time stamp, dBm, field and range.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tdata[31:0] sample_uw
//  m_*       out  tvalid/tready      tdata (see port), tlast last, tuser error
//  cfg_*     in   cfg_we             cfg_index register, cfg_data value
//
//  With the internal trigger on, a sample takes a second logarithm, of the
//  trigger level; a zero sample or zero trigger level skips its logarithm.
//  The 59 squarings of each logarithm dominate, each a 64x64 product made
//  of four 32x32 partial products on the one shared multiplier.
//  Reset clears configuration, trace position and all handshake state.
//  A two-entry queue and the output register let input and output stall
//  independently; error samples skip the arithmetic, dropped ones the queue.
// ----------------------------------------------------------------------------
module power_trace_unit_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] sample_uw
	output logic        m_tvalid,
	input  logic        m_tready,
	// [33:0] time_ns, [47:34] power_dbm, [48] zero_power, [72:49] field_strength,
	// [74:73] range_code, [75] trig_valid, [89:76] trig_dbm, [95:90] zero
	output logic [95:0] m_tdata,
	output logic        m_tlast,
	output logic        m_tuser,   // [0] error
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ptuc_pkg::*;

	cfg_t  cfg_q;
	logic  q_push, q_pop, q_full, q_empty;
	item_t q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAPTURE_ENABLE:   cfg_q.capture_enable   <= cfg_data[0];
				REG_POINT_COUNT:      cfg_q.point_count      <= cfg_data[12:0];
				REG_TRACE_TIME_NS:    cfg_q.trace_time_ns    <= cfg_data;
				REG_TRACE_OFFSET_NS:  cfg_q.trace_offset_ns  <= signed'(cfg_data);
				REG_CAVITY_FACTOR:    cfg_q.cavity_factor    <= cfg_data[23:0];
				REG_TRIG_INTERNAL:    cfg_q.trig_internal    <= cfg_data[0];
				REG_TRIGGER_LEVEL_UW: cfg_q.trigger_level_uw <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ptuc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_wdata)
	);

	ptuc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	ptuc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_item   (q_rdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// File: sv/ptuc_fifo.sv
// ----------------------------------------------------------------------------
// ptuc_fifo
// Short queue of classified samples between the front and the back.
// ----------------------------------------------------------------------------
module ptuc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ptuc_pkg::item_t wdata,
	input  logic           pop,
	output ptuc_pkg::item_t rdata,
	output logic           full,
	output logic           empty
);
	import ptuc_pkg::*;

	item_t mem_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0] wr_ptr_q, rd_ptr_q;
	logic [$clog2(QDEPTH):0]   count_q;

	assign full  = (count_q == ($clog2(QDEPTH)+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/ptuc_front.sv
// ----------------------------------------------------------------------------
// ptuc_front
// Takes samples, keeps the trace position and running maximum, classifies.
// ----------------------------------------------------------------------------
module ptuc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  ptuc_pkg::cfg_t  cfg,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [31:0]     s_tdata,
	input  logic            q_full,
	output logic            q_push,
	output ptuc_pkg::item_t q_item
);
	import ptuc_pkg::*;

	logic [12:0]        sample_index_q;
	logic signed [31:0] running_max_q;

	logic               bad_count;
	logic signed [31:0] p;
	logic [31:0]        mag;
	logic [12:0]        idx;
	logic signed [31:0] new_max;
	logic               is_last;
	range_t             rng;

	assign bad_count = (cfg.point_count == '0) || (cfg.point_count > 13'(MAX_POINTS));
	assign p         = signed'(s_tdata);
	assign mag       = s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;
	// restart when the point count shrank to or below the position
	assign idx       = (sample_index_q >= cfg.point_count) ? '0 : sample_index_q;
	assign new_max   = ((idx == '0) || (p > running_max_q)) ? p : running_max_q;
	assign is_last   = (idx == cfg.point_count - 13'd1);

	always_comb begin
		if (new_max >= RANGE_HI_UW) begin
			rng = RANGE_HIGH;
		end else if (new_max <= RANGE_LO_UW) begin
			rng = RANGE_LOW;
		end else begin
			rng = RANGE_MID;
		end
	end

	// dropped samples are still taken while capture is off
	assign s_tready = !cfg.capture_enable || !q_full;
	assign q_push   = s_tvalid && s_tready && cfg.capture_enable;

	always_comb begin
		q_item            = '0;
		q_item.err        = bad_count;
		q_item.mag        = mag;
		q_item.idx        = idx;
		q_item.last       = is_last && !bad_count;
		q_item.range_code = (is_last && !bad_count) ? rng : RANGE_LOW;
	end

	always_ff @(posedge clk) begin
		if (q_push && !bad_count) begin
			running_max_q <= new_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
		end else if (q_push && !bad_count) begin
			sample_index_q <= is_last ? '0 : idx + 13'd1;
		end
	end

endmodule

// File: sv/ptuc_mul64.sv
// ----------------------------------------------------------------------------
// ptuc_mul64
// 64x64 multiplier built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module ptuc_mul64 (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);
	logic [63:0]  a_q, b_q;
	logic [2:0]   ph_q;
	logic         busy_q;
	logic         done_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sh_s1;
	logic [127:0] acc_q;

	logic        hi_a, hi_b;
	logic [31:0] a_part, b_part;

	assign hi_a   = ph_q[1];
	assign hi_b   = ph_q[0];
	assign a_part = hi_a ? a_q[63:32] : a_q[31:0];
	assign b_part = hi_b ? b_q[63:32] : b_q[31:0];
	assign done   = done_q;
	assign prod   = acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			pp_s1 <= a_part * b_part;
			sh_s1 <= {1'b0, hi_a} + {1'b0, hi_b};
			if (ph_q != 3'd0) begin
				acc_q <= acc_q + ({64'b0, pp_s1} << {sh_s1, 5'b0});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (ph_q == 3'd4);
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= '0;
			end else if (busy_q) begin
				ph_q <= ph_q + 3'd1;
				if (ph_q == 3'd4) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// File: sv/ptuc_back.sv
// ----------------------------------------------------------------------------
// ptuc_back
// Sequencer for time stamp division, field square root and dBm logarithms.
// ----------------------------------------------------------------------------
module ptuc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ptuc_pkg::cfg_t  cfg,
	input  logic            q_empty,
	output logic            q_pop,
	input  ptuc_pkg::item_t q_item,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [95:0]     m_tdata,
	output logic            m_tlast,
	output logic            m_tuser
);
	import ptuc_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_TMUL   = 11'b00000000010,
		ST_DIV    = 11'b00000000100,
		ST_CFMUL  = 11'b00000001000,
		ST_PMUL   = 11'b00000010000,
		ST_SQRT   = 11'b00000100000,
		ST_LSTART = 11'b00001000000,
		ST_NORM   = 11'b00010000000,
		ST_SQ     = 11'b00100000000,
		ST_LMUL   = 11'b01000000000,
		ST_OUT    = 11'b10000000000
	} st_t;

	st_t                st_q;
	item_t              item_q;
	logic               issued_q;
	logic [5:0]         cnt_q;
	logic [44:0]        dvd_q;
	logic [12:0]        rem_q;
	logic signed [33:0] tns_q;
	logic [47:0]        c2_q;
	logic [47:0]        rad_q;
	logic [23:0]        root_q;
	logic [25:0]        srem_q;
	logic               lsel_q;
	logic [63:0]        m_q;
	logic [4:0]         n_q;
	logic [58:0]        frac_q;
	logic signed [13:0] pdbm_q, tdbm_q;
	logic               ovalid_q;
	res_t               ores_q;

	logic         mul_start, mul_done, mul_state;
	logic [63:0]  mul_a, mul_b;
	logic [127:0] mul_prod;

	logic [13:0]  dtrial;
	logic         dge;
	logic [44:0]  dvd_next;
	logic [27:0]  scat, strial;
	logic         sge;
	logic [23:0]  root_next;
	logic [31:0]  log_arg;
	logic [63:0]  sq_m;
	logic [127:0] lrnd;
	logic [15:0]  ldbm;
	logic         out_load;
	res_t         res;

	ptuc_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign mul_state = (st_q == ST_TMUL) || (st_q == ST_CFMUL) || (st_q == ST_PMUL)
		|| (st_q == ST_SQ) || (st_q == ST_LMUL);
	assign mul_start = mul_state && !issued_q;

	always_comb begin
		case (st_q)
			ST_TMUL: begin
				mul_a = {51'b0, item_q.idx};
				mul_b = {32'b0, cfg.trace_time_ns};
			end
			ST_CFMUL: begin
				mul_a = {40'b0, cfg.cavity_factor};
				mul_b = {40'b0, cfg.cavity_factor};
			end
			ST_PMUL: begin
				mul_a = {16'b0, c2_q};
				mul_b = {32'b0, item_q.mag};
			end
			ST_SQ: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			ST_LMUL: begin
				mul_a = {n_q, frac_q};
				mul_b = LOG10_2_X1000_Q54;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// restoring division, one quotient bit a cycle
	assign dtrial   = {rem_q, dvd_q[44]};
	assign dge      = dtrial >= {1'b0, cfg.point_count};
	assign dvd_next = {dvd_q[43:0], dge};

	// digit-by-digit square root, two radicand bits a cycle
	assign scat      = {srem_q, rad_q[47:46]};
	assign strial    = {2'b0, root_q, 2'b01};
	assign sge       = scat >= strial;
	assign root_next = {root_q[22:0], sge};

	assign log_arg = lsel_q ? cfg.trigger_level_uw : item_q.mag;
	// Q1.62 mantissa squared back to Q1.62
	assign sq_m    = mul_prod[125:62];
	assign lrnd    = mul_prod + (128'd1 << 112);
	assign ldbm    = {1'b0, lrnd[127:113]} - 16'd3000;

	assign q_pop    = (st_q == ST_IDLE) && !q_empty;
	assign out_load = (st_q == ST_OUT) && (!ovalid_q || m_tready);

	always_comb begin
		res = '0;
		if (item_q.err) begin
			res.error = 1'b1;
		end else begin
			res.time_ns        = tns_q;
			res.power_dbm      = pdbm_q;
			res.zero_power     = (item_q.mag == '0);
			res.field_strength = root_q;
			res.last           = item_q.last;
			res.range_code     = item_q.range_code;
			res.trig_valid     = cfg.trig_internal;
			res.trig_dbm       = cfg.trig_internal ? tdbm_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (out_load) begin
			ores_q <= res;
		end
		case (st_q)
			ST_TMUL: begin
				if (mul_done) begin
					dvd_q <= mul_prod[44:0];
					rem_q <= '0;
				end
			end
			ST_DIV: begin
				dvd_q <= dvd_next;
				rem_q <= dge ? 13'(dtrial - {1'b0, cfg.point_count}) : dtrial[12:0];
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					tns_q <= 34'(signed'({2'b0, dvd_next[31:0]})) + 34'(cfg.trace_offset_ns);
				end
			end
			ST_CFMUL: begin
				if (mul_done) begin
					c2_q <= mul_prod[47:0];
				end
			end
			ST_PMUL: begin
				if (mul_done) begin
					rad_q  <= mul_prod[79:32];
					root_q <= '0;
					srem_q <= '0;
				end
			end
			ST_SQRT: begin
				rad_q  <= {rad_q[45:0], 2'b00};
				root_q <= root_next;
				srem_q <= sge ? 26'(scat - strial) : scat[25:0];
			end
			ST_LSTART: begin
				m_q    <= {1'b0, log_arg, 31'b0};
				n_q    <= 5'd31;
				frac_q <= '0;
				if (log_arg == '0) begin
					if (lsel_q) begin
						tdbm_q <= DBM_FLOOR;
					end else begin
						pdbm_q <= DBM_FLOOR;
					end
				end
			end
			ST_NORM: begin
				if (!m_q[62]) begin
					m_q <= {m_q[62:0], 1'b0};
					n_q <= n_q - 5'd1;
				end
			end
			ST_SQ: begin
				if (mul_done) begin
					m_q    <= sq_m[63] ? {1'b0, sq_m[63:1]} : sq_m;
					frac_q <= {frac_q[57:0], sq_m[63]};
				end
			end
			ST_LMUL: begin
				if (mul_done) begin
					if (lsel_q) begin
						tdbm_q <= ldbm[13:0];
					end else begin
						pdbm_q <= ldbm[13:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			issued_q <= 1'b0;
			cnt_q    <= '0;
			lsel_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (mul_start) begin
				issued_q <= 1'b1;
			end else if (mul_done) begin
				issued_q <= 1'b0;
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						st_q <= q_item.err ? ST_OUT : ST_TMUL;
					end
				end
				ST_TMUL: begin
					if (mul_done) begin
						cnt_q <= '0;
						st_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DIV_STEPS - 1)) begin
						st_q <= ST_CFMUL;
					end
				end
				ST_CFMUL: begin
					if (mul_done) begin
						st_q <= ST_PMUL;
					end
				end
				ST_PMUL: begin
					if (mul_done) begin
						cnt_q <= '0;
						st_q  <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(SQRT_STEPS - 1)) begin
						lsel_q <= 1'b0;
						st_q   <= ST_LSTART;
					end
				end
				ST_LSTART: begin
					if (log_arg != '0) begin
						st_q <= ST_NORM;
					end else if (!lsel_q && cfg.trig_internal) begin
						lsel_q <= 1'b1;
					end else begin
						st_q <= ST_OUT;
					end
				end
				ST_NORM: begin
					if (m_q[62]) begin
						cnt_q <= '0;
						st_q  <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (mul_done) begin
						cnt_q <= cnt_q + 6'd1;
						if (cnt_q == 6'(SQ_STEPS - 1)) begin
							st_q <= ST_LMUL;
						end
					end
				end
				ST_LMUL: begin
					if (mul_done) begin
						if (!lsel_q && cfg.trig_internal) begin
							lsel_q <= 1'b1;
							st_q   <= ST_LSTART;
						end else begin
							st_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tlast  = ores_q.last;
	assign m_tuser  = ores_q.error;
	assign m_tdata  = {6'b0, ores_q.trig_dbm, ores_q.trig_valid, ores_q.range_code,
		ores_q.field_strength, ores_q.zero_power, ores_q.power_dbm, ores_q.time_ns};

endmodule

// File: sv/ptuc_checker.sv
// ----------------------------------------------------------------------------
// ptuc_checker
// Port-level checks on the result stream of the power trace converter.
// ----------------------------------------------------------------------------
module ptuc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);
	import ptuc_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// an error result carries nothing else
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == '0) && !m_tlast)
		else $error("error result with payload");

	// range code only with the last sample
	a_range_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> (m_tdata[74:73] == RANGE_LOW))
		else $error("range code off the last sample");

	// trigger level zero when not selected
	a_trig_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[75] |-> (m_tdata[89:76] == '0))
		else $error("trigger level without internal trigger");

	// zero power floors the dBm value
	a_zero_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[48] |-> (m_tdata[47:34] == DBM_FLOOR))
		else $error("zero power not floored");

endmodule

bind power_trace_unit_converter ptuc_checker u_ptuc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// File: bench/tb_power_trace_unit_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_power_trace_unit_converter
// Drives power samples through the converter under several register settings
// and compares every result field with an in-bench fixed point calculation.
// ----------------------------------------------------------------------------
module tb_power_trace_unit_converter;
	import ptuc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	power_trace_unit_converter dut (.*);

	// settings and trace position as the block should hold them
	cfg_t               cur;
	logic [12:0]        trace_pos;
	logic signed [31:0] peak_uw;

	logic [31:0] sample_q[$];
	res_t        want_q[$];
	int          fails;
	int unsigned cycles;
	logic        drv_gap_busy;
	int          drv_gap;
	int          mon_gap;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	function automatic logic signed [13:0] dbm_of(input logic [63:0] a);
		logic [127:0] prod;
		logic [63:0]  m;
		logic [63:0]  frac;
		int           n;
		if (a == 0)
			return DBM_FLOOR;
		n = 0;
		while (n < 63 && (a >> (n + 1)) != 0)
			n++;
		m = a << (62 - n);
		frac = 0;
		for (int k = 0; k < 59; k++) begin
			prod = {64'd0, m} * {64'd0, m};
			m = prod[125:62];
			frac = frac << 1;
			if (m[63]) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		prod = {64'd0, (64'(n) << 59) | frac} * {64'd0, LOG10_2_X1000_Q54};
		prod = prod + (128'd1 << 112);
		return 14'(prod[127:113] - 3000);
	endfunction

	function automatic logic [23:0] field_of(input logic [23:0] cf, input logic [31:0] a);
		logic [127:0] target;
		logic [127:0] t;
		logic [23:0]  q;
		target = ({80'd0, cf} * {80'd0, cf}) * {96'd0, a};
		q = 0;
		for (int b = 23; b >= 0; b--) begin
			t = {104'd0, q | (24'd1 << b)};
			if (((t * t) << 32) <= target)
				q = q | (24'd1 << b);
		end
		return q;
	endfunction

	task automatic predict_sample(input logic [31:0] raw);
		res_t               r;
		logic signed [31:0] p;
		logic [31:0]        mag;
		logic [12:0]        idx;
		logic [63:0]        q;
		r = '0;
		p = raw;
		mag = p[31] ? -raw : raw;
		if (!cur.capture_enable)
			return;
		if (cur.point_count == 0 || cur.point_count > MAX_POINTS) begin
			r.error = 1'b1;
			want_q.push_back(r);
			return;
		end
		if (trace_pos >= cur.point_count)
			trace_pos = 0;
		idx = trace_pos;
		if (idx == 0 || p > peak_uw)
			peak_uw = p;
		q = ({51'd0, idx} * {32'd0, cur.trace_time_ns}) / {51'd0, cur.point_count};
		r.time_ns = 34'($signed({1'b0, q}) + cur.trace_offset_ns);
		r.power_dbm = dbm_of({32'd0, mag});
		r.zero_power = (mag == 0);
		r.field_strength = field_of(cur.cavity_factor, mag);
		r.last = (idx == cur.point_count - 1);
		r.range_code = RANGE_LOW;
		if (r.last) begin
			if (peak_uw >= RANGE_HI_UW)
				r.range_code = RANGE_HIGH;
			else if (peak_uw > RANGE_LO_UW)
				r.range_code = RANGE_MID;
			trace_pos = 0;
		end else begin
			trace_pos = idx + 1;
		end
		r.trig_valid = cur.trig_internal;
		r.trig_dbm = cur.trig_internal ? dbm_of({32'd0, cur.trigger_level_uw}) : 14'sd0;
		want_q.push_back(r);
	endtask

	// driver: prediction happens at acceptance so it follows register order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			drv_gap <= 0;
		end else if (s_tvalid && !s_tready) begin
			// hold the request
		end else begin
			if (s_tvalid)
				predict_sample(s_tdata);
			if (drv_gap > 0) begin
				drv_gap <= drv_gap - 1;
				s_tvalid <= 1'b0;
			end else if (sample_q.size() > 0 && !drv_gap_busy) begin
				s_tvalid <= 1'b1;
				s_tdata <= sample_q.pop_front();
				drv_gap <= ($urandom_range(0, 9) < 4) ? 0 :
					($urandom_range(0, 19) == 0 ? $urandom_range(20, 200) :
					$urandom_range(1, 4));
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			mon_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (want_q.size() == 0) begin
					$error("result with nothing expected");
					fails++;
				end else begin
					res_t e;
					e = want_q.pop_front();
					check_field("time_ns", 64'(unsigned'(e.time_ns)), 64'(m_tdata[33:0]));
					check_field("power_dbm", 64'(unsigned'(e.power_dbm)),
						64'(m_tdata[47:34]));
					check_field("zero_power", 64'(e.zero_power), 64'(m_tdata[48]));
					check_field("field_strength", 64'(e.field_strength), 64'(m_tdata[72:49]));
					check_field("range_code", 64'(e.range_code), 64'(m_tdata[74:73]));
					check_field("trig_valid", 64'(e.trig_valid), 64'(m_tdata[75]));
					check_field("trig_dbm", 64'(unsigned'(e.trig_dbm)), 64'(m_tdata[89:76]));
					check_field("pad", 64'd0, 64'(m_tdata[95:90]));
					check_field("last", 64'(e.last), 64'(m_tlast));
					check_field("error", 64'(e.error), 64'(m_tuser));
				end
			end
			if (mon_gap > 0) begin
				mon_gap <= mon_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 9) < 3)
					mon_gap <= ($urandom_range(0, 14) == 0) ? $urandom_range(50, 1500) :
						$urandom_range(1, 5);
			end
		end
	end

	task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		case (r)
			REG_CAPTURE_ENABLE:   cur.capture_enable = v[0];
			REG_POINT_COUNT:      cur.point_count = v[12:0];
			REG_TRACE_TIME_NS:    cur.trace_time_ns = v;
			REG_TRACE_OFFSET_NS:  cur.trace_offset_ns = v;
			REG_CAVITY_FACTOR:    cur.cavity_factor = v[23:0];
			REG_TRIG_INTERNAL:    cur.trig_internal = v[0];
			REG_TRIGGER_LEVEL_UW: cur.trigger_level_uw = v;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for the block to drain, including a dropped or queued sample
	task automatic settle;
		while (sample_q.size() > 0 || s_tvalid || want_q.size() > 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic load_setting(input logic en, input int pc, input logic [31:0] tt,
			input logic [31:0] off, input logic [23:0] cf, input logic ti,
			input logic [31:0] tl);
		settle();
		write_reg(REG_CAPTURE_ENABLE, {31'd0, en});
		write_reg(REG_POINT_COUNT, 32'(pc));
		write_reg(REG_TRACE_TIME_NS, tt);
		write_reg(REG_TRACE_OFFSET_NS, off);
		write_reg(REG_CAVITY_FACTOR, cf);
		write_reg(REG_TRIG_INTERNAL, {31'd0, ti});
		write_reg(REG_TRIGGER_LEVEL_UW, tl);
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1000);
			2: return $urandom_range(0, 2000000);
			3: return 32'($urandom_range(900000000, 2147483647));
			4: return -32'($urandom_range(0, 100000));
			default: return $urandom() >> $urandom_range(0, 31);
		endcase
	endfunction

	initial begin
		cur = '0;
		trace_pos = 0;
		peak_uw = 0;
		fails = 0;
		cycles = 0;
		drv_gap_busy = 1'b1;
		cfg_we = 1'b0;
		cfg_index = REG_CAPTURE_ENABLE;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		drv_gap_busy = 1'b0;

		// directed: disabled capture drops, bad counts, field extremes
		sample_q.push_back(32'd5);
		load_setting(1'b1, 0, 32'd100, 32'd0, 24'd0, 1'b0, 32'd0);
		sample_q.push_back(32'd7);
		load_setting(1'b1, MAX_POINTS + 1, 32'd100, 32'd0, 24'd0, 1'b1, 32'd0);
		sample_q.push_back(32'd7);
		load_setting(1'b1, 8191, 32'd100, 32'd0, 24'hFFFFFF, 1'b1, 32'hFFFFFFFF);
		sample_q.push_back(32'd1);
		load_setting(1'b1, 8, 32'hFFFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF, 1'b1, 32'd0);
		sample_q.push_back(32'd0);
		sample_q.push_back(32'h80000000);
		sample_q.push_back(32'h7FFFFFFF);
		sample_q.push_back(32'hFFFFFFFF);
		sample_q.push_back(32'd1);
		sample_q.push_back(32'd1000000);
		sample_q.push_back(32'd1000001);
		sample_q.push_back(32'd999999999);
		load_setting(1'b1, 4, 32'd1000, 32'h80000000, 24'd65536, 1'b1, 32'd1000);
		sample_q.push_back(32'd1000000000);
		sample_q.push_back(32'd10);
		// shrink count mid-trace so the position wraps
		load_setting(1'b1, 1, 32'd0, 32'd0, 24'd1, 1'b0, 32'd1);
		sample_q.push_back(32'd100);
		sample_q.push_back(32'd0);
		load_setting(1'b1, MAX_POINTS, 32'd123456, 32'hFFFFFF00, 24'd300000, 1'b1,
			32'd5);
		sample_q.push_back(32'd42);
		sample_q.push_back(32'd2000000);

		// random phases with fresh settings; mostly short valid traces
		for (int ph = 0; ph < 30; ph++) begin
			int pc;
			case ($urandom_range(0, 9))
				0: pc = 0;
				1: pc = $urandom_range(MAX_POINTS + 1, 8191);
				2: pc = MAX_POINTS;
				default: pc = $urandom_range(1, 40);
			endcase
			load_setting($urandom_range(0, 9) != 0, pc, $urandom(), $urandom(),
				24'($urandom()), $urandom_range(0, 1), $urandom() >> $urandom_range(0, 31));
			for (int i = 0; i < 31; i++)
				sample_q.push_back(rand_sample());
		end

		settle();
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		if (cycles > 20000000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
